>>> sv/svms_pkg.sv
// Shared types and constants for the servo valve move-and-settle unit
`timescale 1ns / 1ps
`default_nettype none

package svms_pkg;

  // configuration port shape
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_POS_MIN    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_POS_MAX    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TOL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACCEPT_TOL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STABLE_NEED = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_MIN  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_MAX  = 3'd7;

  // full scale in percent and stable counter ceiling
  localparam logic [6:0] PCT_FULL   = 7'd100;
  localparam logic [3:0] STABLE_SAT = 4'd15;

  // floor(m / 100) = (m * RECIP_100) >> RECIP_100_SH for m below 2^22
  localparam logic [22:0] RECIP_100    = 23'd5368710;
  localparam int          RECIP_100_SH = 29;

  // 20 ms period in us is 625 * 32, so the divide splits into a shift
  // and floor(y / 625) = (y * RECIP_625) >> RECIP_625_SH for y below 2^26
  localparam int          PERIOD_SH    = 5;
  localparam logic [26:0] RECIP_625    = 27'd109951163;
  localparam int          RECIP_625_SH = 36;

  typedef struct packed {
    logic [6:0]  pos_min;
    logic [6:0]  pos_max;
    logic [6:0]  settle_tol;
    logic [6:0]  accept_tol;
    logic [3:0]  stable_needed;
    logic [15:0] timeout_polls;
    logic [14:0] pulse_min_us;
    logic [14:0] pulse_max_us;
  } svms_cfg_t;

  // one input item after the sample has been mapped to percent
  typedef struct packed {
    logic       mode;
    logic [7:0] target;
    logic [6:0] act;
  } svms_item_t;

  // result of the control step, prod is the signed pos * pulse span
  typedef struct packed {
    logic        has_res;
    logic        duty_valid;
    logic        done;
    logic        executed;
    logic        timed_out;
    logic [6:0]  actual;
    logic [15:0] elapsed;
    logic [22:0] prod;
  } svms_res_t;

endpackage

`default_nettype wire

>>> sv/svms_move_ctrl.sv
// Move and settle state: command check, poll counting, settle and timeout decision
`timescale 1ns / 1ps
`default_nettype none

module svms_move_ctrl import svms_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  svms_item_t item_i,
  input  svms_cfg_t  cfg_i,
  output svms_res_t  res_o
);

  logic [6:0]  cur_pos_q, cur_pos_d;
  logic [6:0]  tgt_q, tgt_d;
  logic        busy_q, busy_d;
  logic [3:0]  stable_q, stable_d;
  logic [15:0] poll_q, poll_d;

  logic               reject;
  logic [6:0]         pos;
  logic signed [15:0] span;
  logic signed [22:0] pos_x, span_x, prod_s;
  logic [15:0]        poll_n;
  logic [3:0]         stable_n;
  logic [6:0]         dist_act;
  logic               in_tol, settled, finish;

  // absolute distance of two percent values
  function automatic logic [6:0] pct_dist(input logic [6:0] a, input logic [6:0] b);
    pct_dist = (a > b) ? (a - b) : (b - a);
  endfunction

  // set command check and pulse span product
  always_comb begin
    reject = busy_q
          || ($signed(item_i.target) < $signed({1'b0, cfg_i.pos_min}))
          || ($signed(item_i.target) > $signed({1'b0, cfg_i.pos_max}));
    pos    = (item_i.target[6:0] > PCT_FULL) ? PCT_FULL : item_i.target[6:0];
    span   = $signed({1'b0, cfg_i.pulse_max_us}) - $signed({1'b0, cfg_i.pulse_min_us});
    pos_x  = 23'(pos);
    span_x = 23'(span);
    prod_s = pos_x * span_x;
  end

  // poll evaluation
  always_comb begin
    poll_n   = poll_q + 16'd1;
    dist_act = pct_dist(item_i.act, tgt_q);
    in_tol   = (dist_act <= cfg_i.settle_tol);
    if (!in_tol) begin
      stable_n = '0;
    end else if (stable_q < STABLE_SAT) begin
      stable_n = stable_q + 4'd1;
    end else begin
      stable_n = stable_q;
    end
    settled = in_tol && (stable_n >= cfg_i.stable_needed);
    finish  = settled || !(poll_n < cfg_i.timeout_polls);
  end

  // next state and result
  always_comb begin
    cur_pos_d = cur_pos_q;
    tgt_d     = tgt_q;
    busy_d    = busy_q;
    stable_d  = stable_q;
    poll_d    = poll_q;
    res_o     = '0;
    if (fire_i) begin
      if (!item_i.mode) begin
        res_o.has_res = 1'b1;
        if (reject) begin
          res_o.done   = 1'b1;
          res_o.actual = cur_pos_q;
        end else begin
          res_o.duty_valid = 1'b1;
          res_o.prod       = prod_s;
          cur_pos_d        = pos;
          tgt_d            = pos;
          busy_d           = 1'b1;
          stable_d         = '0;
          poll_d           = '0;
        end
      end else if (busy_q) begin
        poll_d   = poll_n;
        stable_d = stable_n;
        if (finish) begin
          res_o.has_res   = 1'b1;
          res_o.done      = 1'b1;
          res_o.executed  = (dist_act <= cfg_i.accept_tol);
          res_o.timed_out = !settled;
          res_o.actual    = item_i.act;
          res_o.elapsed   = poll_n;
          cur_pos_d       = item_i.act;
          busy_d          = 1'b0;
          stable_d        = '0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pos_q <= '0;
      tgt_q     <= '0;
      busy_q    <= 1'b0;
      stable_q  <= '0;
      poll_q    <= '0;
    end else begin
      cur_pos_q <= cur_pos_d;
      tgt_q     <= tgt_d;
      busy_q    <= busy_d;
      stable_q  <= stable_d;
      poll_q    <= poll_d;
    end
  end

  // a finish always leaves the unit idle, an issued duty always leaves it busy
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.mode && res_o.has_res |=> !busy_q)
    else $error("finish did not return to idle");

  a_duty_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.duty_valid |=> busy_q && (poll_q == '0) && (stable_q == '0))
    else $error("issued duty did not start a clean wait");

  a_busy_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.mode && busy_q |-> !res_o.duty_valid)
    else $error("set command accepted while busy");

endmodule

`default_nettype wire

>>> sv/servo_valve_move_and_settle_unit.sv
// Top level of the servo valve move-and-settle unit with duty mapping pipeline
`timescale 1ns / 1ps
`default_nettype none

// Takes one transfer per clock on the slave side while s_axis_tready is high: a set
// command (tuser 0) with a signed target percent, or a poll tick (tuser 1) with a
// feedback sample. A set command gives one result at once: either an issued servo
// duty (tuser 1 on the master side) or a rejection with the current position. A
// poll gives a result only when the move settles or times out. A result passes the
// input register, two duty mapping stages and the output register; the depth comes
// from the pulse and duty arithmetic, which has a multiplier in each stage: pos *
// span, divide by 100, divide by the 20 ms period. Each stage only holds back when
// it is full and the next one is, so new items can still move into empty stages
// while a result waits on the master side. Registers are written through cfg_we_i;
// the user must write them only while the unit is idle; nothing in the unit enforces this.
module servo_valve_move_and_settle_unit import svms_pkg::*; #(
  parameter int DUTY_BITS   = 13,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // register write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: target_position[7:0], feedback_sample, zero fill
  input  logic [((8+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: mode
  input  logic                 s_axis_tuser,
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: servo_duty, done_res, executed, timed_out, report_pos,
  // elapsed_polls, zero fill
  output logic [((DUTY_BITS+26+7)/8)*8-1:0] m_axis_tdata,
  // tuser: duty_valid
  output logic                 m_axis_tuser
);

  localparam int OutW  = ((DUTY_BITS + 26 + 7) / 8) * 8;
  localparam int X100W = SAMPLE_BITS + 7;
  localparam int YW    = DUTY_BITS + 10;
  localparam int QdW   = DUTY_BITS + 37;
  localparam logic [SAMPLE_BITS:0] SmpMax = (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - 1);

  // configuration registers
  svms_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_POS_MIN:     cfg_d.pos_min       = cfg_wdata_i[6:0];
        CFG_POS_MAX:     cfg_d.pos_max       = cfg_wdata_i[6:0];
        CFG_SETTLE_TOL:  cfg_d.settle_tol    = cfg_wdata_i[6:0];
        CFG_ACCEPT_TOL:  cfg_d.accept_tol    = cfg_wdata_i[6:0];
        CFG_STABLE_NEED: cfg_d.stable_needed = cfg_wdata_i[3:0];
        CFG_TIMEOUT:     cfg_d.timeout_polls = cfg_wdata_i[15:0];
        CFG_PULSE_MIN:   cfg_d.pulse_min_us  = cfg_wdata_i[14:0];
        CFG_PULSE_MAX:   cfg_d.pulse_max_us  = cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min       <= 7'd0;
      cfg_q.pos_max       <= 7'd100;
      cfg_q.settle_tol    <= 7'd3;
      cfg_q.accept_tol    <= 7'd5;
      cfg_q.stable_needed <= 4'd3;
      cfg_q.timeout_polls <= 16'd100;
      cfg_q.pulse_min_us  <= 15'd500;
      cfg_q.pulse_max_us  <= 15'd2500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // stage handshake
  logic v_a_q, v_b_q, v_c_q, v_o_q;
  logic rdy_a, rdy_b, rdy_c, rdy_o;
  logic fire_a;

  assign rdy_o  = !v_o_q || m_axis_tready;
  assign rdy_c  = !v_c_q || rdy_o;
  assign rdy_b  = !v_b_q || rdy_c;
  assign rdy_a  = !v_a_q || rdy_b;
  assign fire_a = v_a_q && rdy_b;
  assign s_axis_tready = rdy_a;

  // feedback sample to percent: s * 100 / (2^n - 1), quotient by shift plus one correction
  logic [SAMPLE_BITS-1:0] smp;
  logic [X100W-1:0]       smp_x100;
  logic [6:0]             pct_q0, pct;
  logic [SAMPLE_BITS:0]   pct_rem;

  always_comb begin
    smp      = s_axis_tdata[8 +: SAMPLE_BITS];
    smp_x100 = X100W'(smp) * X100W'(PCT_FULL);
    pct_q0   = smp_x100[X100W-1:SAMPLE_BITS];
    pct_rem  = {1'b0, smp_x100[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(pct_q0);
    pct      = (pct_rem >= SmpMax) ? (pct_q0 + 7'd1) : pct_q0;
  end

  // input register
  svms_item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else if (rdy_a) begin
      v_a_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy_a) begin
      item_q.mode   <= s_axis_tuser;
      item_q.target <= s_axis_tdata[7:0];
      item_q.act    <= pct;
    end
  end

  // control step
  svms_res_t res_a;

  svms_move_ctrl u_move_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire_a),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_a)
  );

  // stage b register
  svms_res_t res_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q <= 1'b0;
    end else if (rdy_b) begin
      v_b_q <= fire_a && res_a.has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      res_b_q <= res_a;
    end
  end

  // pulse = pulse_min + pos * span / 100, truncated toward zero
  logic signed [22:0] prod_s;
  logic               prod_neg;
  logic [22:0]        prod_mag;
  logic [44:0]        q100_full;
  logic [14:0]        q100;
  logic signed [16:0] q100_s, pulse_s;
  logic [14:0]        pulse;

  always_comb begin
    prod_s    = $signed(res_b_q.prod);
    prod_neg  = prod_s[22];
    prod_mag  = prod_neg ? 23'(-prod_s) : 23'(prod_s);
    q100_full = 45'(prod_mag[21:0]) * 45'(RECIP_100);
    q100      = q100_full[RECIP_100_SH +: 15];
    q100_s    = $signed({2'b00, q100});
    pulse_s   = $signed({2'b00, cfg_q.pulse_min_us}) + (prod_neg ? -q100_s : q100_s);
    pulse     = pulse_s[16] ? '0 : pulse_s[14:0];
  end

  // stage c register
  svms_res_t   res_c_q;
  logic [14:0] pulse_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c_q <= 1'b0;
    end else if (rdy_c) begin
      v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      res_c_q   <= res_b_q;
      pulse_c_q <= pulse;
    end
  end

  // duty = pulse * 2^DUTY_BITS / 20000, saturated, zero for results without a duty
  logic [YW-1:0]        duty_y;
  logic [QdW-1:0]       qd_full;
  logic [DUTY_BITS:0]   qd;
  logic [DUTY_BITS-1:0] duty;

  always_comb begin
    duty_y  = YW'(pulse_c_q) << (DUTY_BITS - PERIOD_SH);
    qd_full = QdW'(duty_y) * QdW'(RECIP_625);
    qd      = qd_full[RECIP_625_SH +: DUTY_BITS+1];
    if (!res_c_q.duty_valid) begin
      duty = '0;
    end else if (qd[DUTY_BITS]) begin
      duty = '1;
    end else begin
      duty = qd[DUTY_BITS-1:0];
    end
  end

  // output register
  svms_res_t            res_o_q;
  logic [DUTY_BITS-1:0] duty_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
    end else if (rdy_o) begin
      v_o_q <= v_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      res_o_q  <= res_c_q;
      duty_o_q <= duty;
    end
  end

  assign m_axis_tvalid = v_o_q;
  assign m_axis_tuser  = res_o_q.duty_valid;
  assign m_axis_tdata  = OutW'({res_o_q.elapsed, res_o_q.actual, res_o_q.timed_out,
                                res_o_q.executed, res_o_q.done, duty_o_q});

  // an issued duty never carries finish status
  a_duty_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_o_q && res_o_q.duty_valid |-> !res_o_q.done && !res_o_q.timed_out)
    else $error("duty result carries finish status");

  // finish flags only come with done
  a_flags_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_o_q && (res_o_q.executed || res_o_q.timed_out) |-> res_o_q.done)
    else $error("finish flag without done");

  // reported position stays in range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_o_q |-> res_o_q.actual <= PCT_FULL)
    else $error("reported position above full scale");

  // a held stage item is not dropped
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_b_q && !rdy_c |=> v_b_q)
    else $error("stalled item lost in duty pipeline");

endmodule

`default_nettype wire
